FILE: design/bmh_pkg.sv
// ----------------------------------------------------------------------------
// bmh_pkg: shared definitions for the binary min-heap engine
// Sizes of the key store, key width, operation and status codes.
// ----------------------------------------------------------------------------
package bmh_pkg;

	localparam int DEPTH  = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = ADDR_W + 1;
	localparam int KEY_W  = 32;
	localparam int CAP_W  = 11;

	localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic signed [KEY_W-1:0] KEY_NONE = {KEY_W{1'b1}};

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_DELETE  = 2'd1,
		OP_EXTRACT = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

endpackage

FILE: design/binary_min_heap_engine.sv
// ----------------------------------------------------------------------------
// binary_min_heap_engine: priority queue of signed keys in a binary min-heap
// Insert, delete-at-index and extract-min over a key store with one write
// and one read port, sequenced one memory read per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*): one transaction per operation. s_tuser carries the
//   opcode, s_tdata the key (insert) and the slot index (delete).
//   Master stream (m_*): exactly one transaction per operation, in order.
//   m_tdata carries the extracted key (-1 on an extract from an empty heap, 0 for
//   other operations), m_tuser the status code.
//   Config channel (cfg_*): writes capacity_limit; always ready. Write it only
//   while no operation is in flight.
// Timing:
//   One operation at a time; s_tready is high only while the sequencer idles.
//   Rejected and no-op operations go straight to the result state. Sift-up
//   works per level by parent read, then compare and move; sift-down by left
//   read, right read, then compare and move; extract first fetches root and
//   last entry. The worst case is a delete of the last slot at 1024 entries
//   (sift-up over 10 levels, then sift-down over 9 levels), paced by the
//   single read port of the key store.
// Reset:
//   Clears the entry count and sets capacity_limit to 1024; the key store is
//   not cleared, since only slots below the count are ever read.
// Stall:
//   A finished result holds in the output register; the next operation is
//   accepted and worked on meanwhile, and waits in its final state.
// ----------------------------------------------------------------------------
module binary_min_heap_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	// s_tdata: key_in [31:0], position [41:32], zero fill [47:42]
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [47:0]               s_tdata,
	// s_tuser: opcode [1:0]
	input  logic [1:0]                s_tuser,
	// m_tdata: value_out [31:0]
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [31:0]               m_tdata,
	// m_tuser: status [1:0]
	output logic [1:0]                m_tuser,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bmh_pkg::CAP_W-1:0] cfg_data
);
	import bmh_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP,
		S_UP_CMP,
		S_TR_RD0,
		S_TR_RD1,
		S_TR_LAST,
		S_DN,
		S_DN_L,
		S_DN_R,
		S_FIN
	} state_t;

	state_t                   state_q;
	op_t                      op_q;
	logic signed [KEY_W-1:0]  cur_q;     // key being sifted (fills the hole)
	logic [ADDR_W-1:0]        idx_q;     // current hole
	logic [ADDR_W-1:0]        par_q;     // parent of the hole during sift-up
	logic [CNT_W-1:0]         cnt_q;
	logic [CAP_W-1:0]         cap_q;
	logic signed [KEY_W-1:0]  lkey_q;    // left child key during sift-down
	logic signed [KEY_W-1:0]  rd_q;      // registered memory read data
	logic signed [KEY_W-1:0]  res_val_q;
	status_t                  res_stat_q;
	logic                     m_tvalid_q;
	logic [31:0]              m_tdata_q;
	logic [1:0]               m_tuser_q;

	logic signed [KEY_W-1:0]  mem [DEPTH];

	// Memory port controls
	logic                     we_c;
	logic [ADDR_W-1:0]        wa_c;
	logic signed [KEY_W-1:0]  wd_c;
	logic [ADDR_W-1:0]        ra_c;

	// Input fields
	op_t                      in_op;
	logic signed [KEY_W-1:0]  in_key;
	logic [ADDR_W-1:0]        in_pos;

	// Derived values
	logic [CNT_W-1:0]         cap_eff;
	logic [ADDR_W-1:0]        parent_c;
	logic [CNT_W-1:0]         left_c;
	logic [CNT_W-1:0]         right_c;
	logic [CNT_W-1:0]         last_c;
	logic                     sel_l;
	logic                     sel_r;
	logic signed [KEY_W-1:0]  best_l;

	assign in_op  = op_t'(s_tuser);
	assign in_key = s_tdata[KEY_W-1:0];
	assign in_pos = s_tdata[KEY_W +: ADDR_W];

	// Effective capacity: the register, clipped to the store depth
	assign cap_eff = (cap_q > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_q);

	assign parent_c = (idx_q - ADDR_W'(1)) >> 1;
	assign left_c   = {idx_q, 1'b1};
	assign right_c  = left_c + CNT_W'(1);
	assign last_c   = cnt_q - CNT_W'(1);

	// Sift-down choice: left first, right only when strictly smaller
	assign sel_l  = lkey_q < cur_q;
	assign best_l = sel_l ? lkey_q : cur_q;
	assign sel_r  = (right_c < cnt_q) && (rd_q < best_l);

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	// Memory access per state
	always_comb begin
		we_c = 1'b0;
		wa_c = idx_q;
		wd_c = cur_q;
		ra_c = '0;
		unique case (state_q)
			S_UP: begin
				if (idx_q == '0) begin
					we_c = 1'b1;
				end else begin
					ra_c = parent_c;
				end
			end
			S_UP_CMP: begin
				we_c = 1'b1;
				if (rd_q > cur_q) begin
					wd_c = rd_q;
				end
			end
			S_TR_RD0: begin
				ra_c = '0;
			end
			S_TR_RD1: begin
				ra_c = last_c[ADDR_W-1:0];
			end
			S_DN: begin
				if (left_c >= cnt_q) begin
					we_c = 1'b1;
				end else begin
					ra_c = left_c[ADDR_W-1:0];
				end
			end
			S_DN_L: begin
				ra_c = right_c[ADDR_W-1:0];
			end
			S_DN_R: begin
				we_c = 1'b1;
				if (sel_r) begin
					wd_c = rd_q;
				end else if (sel_l) begin
					wd_c = lkey_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Key store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[wa_c] <= wd_c;
		end
		rd_q <= mem[ra_c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			cap_q      <= CAP_W'(DEPTH);
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
			op_q       <= OP_NOP;
			cur_q      <= '0;
			idx_q      <= '0;
			par_q      <= '0;
			lkey_q     <= '0;
			res_val_q  <= '0;
			res_stat_q <= ST_DONE;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			// Drop the result once the receiver takes it
			if (m_tvalid_q && m_tready && state_q != S_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q      <= in_op;
						res_val_q <= (in_op == OP_EXTRACT && cnt_q == '0) ? KEY_NONE : '0;
						unique case (in_op)
							OP_INSERT: begin
								if (cnt_q >= cap_eff) begin
									res_stat_q <= ST_FULL;
									state_q    <= S_FIN;
								end else begin
									res_stat_q <= ST_DONE;
									cur_q      <= in_key;
									idx_q      <= cnt_q[ADDR_W-1:0];
									cnt_q      <= cnt_q + CNT_W'(1);
									state_q    <= S_UP;
								end
							end
							OP_DELETE: begin
								if (cnt_q == '0) begin
									res_stat_q <= ST_EMPTY;
									state_q    <= S_FIN;
								end else if (CNT_W'(in_pos) >= cnt_q) begin
									res_stat_q <= ST_RANGE;
									state_q    <= S_FIN;
								end else begin
									// Force the entry to the root, then extract it
									res_stat_q <= ST_DONE;
									cur_q      <= KEY_MIN;
									idx_q      <= in_pos;
									state_q    <= S_UP;
								end
							end
							OP_EXTRACT: begin
								if (cnt_q == '0) begin
									res_stat_q <= ST_EMPTY;
									state_q    <= S_FIN;
								end else begin
									res_stat_q <= ST_DONE;
									state_q    <= S_TR_RD0;
								end
							end
							default: begin
								res_stat_q <= ST_DONE;
								state_q    <= S_FIN;
							end
						endcase
					end
				end
				S_UP: begin
					if (idx_q == '0) begin
						state_q <= (op_q == OP_DELETE) ? S_TR_RD0 : S_FIN;
					end else begin
						par_q   <= parent_c;
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					// Move the parent down into the hole, or settle the key here
					if (rd_q > cur_q) begin
						idx_q   <= par_q;
						state_q <= S_UP;
					end else begin
						state_q <= (op_q == OP_DELETE) ? S_TR_RD0 : S_FIN;
					end
				end
				S_TR_RD0: begin
					state_q <= S_TR_RD1;
				end
				S_TR_RD1: begin
					if (op_q == OP_EXTRACT) begin
						res_val_q <= rd_q;
					end
					state_q <= S_TR_LAST;
				end
				S_TR_LAST: begin
					// Last entry refills the root hole
					cur_q   <= rd_q;
					idx_q   <= '0;
					cnt_q   <= last_c;
					state_q <= S_DN;
				end
				S_DN: begin
					state_q <= (left_c >= cnt_q) ? S_FIN : S_DN_L;
				end
				S_DN_L: begin
					lkey_q  <= rd_q;
					state_q <= S_DN_R;
				end
				S_DN_R: begin
					if (sel_r) begin
						idx_q   <= right_c[ADDR_W-1:0];
						state_q <= S_DN;
					end else if (sel_l) begin
						idx_q   <= left_c[ADDR_W-1:0];
						state_q <= S_DN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// Hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_val_q;
						m_tuser_q  <= res_stat_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
